FILE: src/rc4_variant_stream_cipher_defines.svh
// assertion macros shared by the rc4 variant cipher rtl
`ifndef RC4_VARIANT_STREAM_CIPHER_DEFINES_SVH
`define RC4_VARIANT_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define RC4V_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rc4v check failed");

// next-cycle implication, checked out of reset
`define RC4V_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rc4v check failed");

`else

`define RC4V_ASSERT_NOW(label, ante, cons)
`define RC4V_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/rc4v_pkg.sv
// types and constants shared by the rc4 variant cipher modules
package rc4v_pkg;

   // permutation offset applied when the table is filled
   localparam logic [7:0] PERM_OFFSET = 8'd5;

   // key bytes used cyclically by the schedule
   localparam int KEY_BYTES = 8;
   localparam int KEY_IDX_W = 3;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_ADDR = '0;

   // one access to the permutation memory
   typedef struct packed {
      logic       we;
      logic [7:0] waddr;
      logic [7:0] wdata;
      logic [7:0] raddr;
   } perm_req_type;

endpackage

FILE: src/rc4v_perm_ram.sv
// 256 x 8 permutation memory, one write port and one registered read port
module rc4v_perm_ram (
   input  logic                   clock,
   input  rc4v_pkg::perm_req_type perm_req,
   output logic [7:0]             rd_data
);
   import rc4v_pkg::*;

   logic [7:0] perm_mem_ff [256];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (perm_req.we) begin
         perm_mem_ff[perm_req.waddr] <= perm_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= perm_mem_ff[perm_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rc4_variant_stream_cipher.sv
// top level of the rc4 variant stream cipher: sequencer, shared adder, csr and output register
// a new input byte is taken only in idle, so each byte is finished before the next is accepted
// the first item of a message first fills the table, then runs the key swap pass (states ka to kd)
// this sequence is set by the single read and single write port of the permutation memory
// reset (synchronous, active high) clears the key, indices and handshake state;
// the permutation memory is not cleared and is always filled before it is read
module rc4_variant_stream_cipher (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_of_message,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rc4v_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rc4v_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rc4v_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rc4v_pkg::*;

`include "rc4_variant_stream_cipher_defines.svh"

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FILL = 4'd1;
   localparam logic [3:0] ST_KA   = 4'd2;
   localparam logic [3:0] ST_KB   = 4'd3;
   localparam logic [3:0] ST_KC   = 4'd4;
   localparam logic [3:0] ST_KD   = 4'd5;
   localparam logic [3:0] ST_GA   = 4'd6;
   localparam logic [3:0] ST_GB   = 4'd7;
   localparam logic [3:0] ST_GC   = 4'd8;
   localparam logic [3:0] ST_GD   = 4'd9;
   localparam logic [3:0] ST_GE   = 4'd10;
   localparam logic [3:0] ST_GF   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [7:0]            n_ff, n_in;
   logic [KEY_IDX_W-1:0]  kidx_ff, kidx_in;
   logic [7:0]            i_ff, i_in;
   logic [7:0]            j_ff, j_in;
   logic [7:0]            si_ff, si_in;
   logic [7:0]            sj_ff, sj_in;
   logic [7:0]            data_ff, data_in;
   logic                  last_ff, last_in;
   logic                  sched_done_ff, sched_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic [CSR_DATA_W-1:0] key_ff, key_in;

   logic [7:0]            add_a, add_b, add_c, add_sum;
   logic [7:0]            key_byte;
   logic [7:0]            rd_data;
   logic                  rsp_load;
   logic                  csr_wr;
   perm_req_type          perm_req;

   // shared adder
   assign add_sum = add_a + add_b + add_c;

   // current key byte of the schedule
   assign key_byte = key_ff[{kidx_ff, 3'b000} +: 8];

   // output register can take a result
   assign rsp_load = (state_ff == ST_GF) && (!rsp_valid_ff || !rsp_stall);

   // configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_KEY_ADDR) ? key_ff : '0;
   assign key_in     = (csr_wr && csr_paddr == CSR_KEY_ADDR) ? csr_pwdata : key_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      kidx_in       = kidx_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      sched_done_in = sched_done_ff;
      add_a         = '0;
      add_b         = '0;
      add_c         = '0;
      perm_req      = '{we: 1'b0, waddr: n_ff, wdata: 8'd0, raddr: n_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               data_in  = req_data_byte;
               last_in  = req_last_of_message;
               n_in     = '0;
               state_in = sched_done_ff ? ST_GA : ST_FILL;
            end
         end
         // table entry n holds n plus offset
         ST_FILL: begin
            add_a          = n_ff;
            add_b          = PERM_OFFSET;
            perm_req.we    = 1'b1;
            perm_req.wdata = add_sum;
            n_in           = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               j_in     = '0;
               kidx_in  = '0;
               state_in = ST_KA;
            end
         end
         // schedule step: read s[n]
         ST_KA: begin
            state_in = ST_KB;
         end
         // j += s[n] + key, read s[j]
         ST_KB: begin
            si_in          = rd_data;
            add_a          = j_ff;
            add_b          = rd_data;
            add_c          = key_byte;
            j_in           = add_sum;
            perm_req.raddr = add_sum;
            state_in       = ST_KC;
         end
         // s[n] = s[j]
         ST_KC: begin
            sj_in          = rd_data;
            perm_req.we    = 1'b1;
            perm_req.wdata = rd_data;
            state_in       = ST_KD;
         end
         // s[j] = old s[n], advance step
         ST_KD: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            n_in           = n_ff + 8'd1;
            kidx_in        = (kidx_ff == KEY_IDX_W'(KEY_BYTES - 1)) ? '0 : kidx_ff + 1'b1;
            if (n_ff == 8'hFF) begin
               i_in          = '0;
               j_in          = '0;
               sched_done_in = 1'b1;
               state_in      = ST_GA;
            end else begin
               state_in = ST_KA;
            end
         end
         // i += 1, read s[i]
         ST_GA: begin
            add_a          = i_ff;
            add_b          = 8'd1;
            i_in           = add_sum;
            perm_req.raddr = add_sum;
            state_in       = ST_GB;
         end
         // j += s[i], read s[j]
         ST_GB: begin
            si_in          = rd_data;
            add_a          = j_ff;
            add_b          = rd_data;
            j_in           = add_sum;
            perm_req.raddr = add_sum;
            state_in       = ST_GC;
         end
         // s[i] = s[j]
         ST_GC: begin
            sj_in          = rd_data;
            perm_req.we    = 1'b1;
            perm_req.waddr = i_ff;
            perm_req.wdata = rd_data;
            state_in       = ST_GD;
         end
         // s[j] = old s[i]
         ST_GD: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            state_in       = ST_GE;
         end
         // keystream read at s[i] + s[j]; held while the output is stalled
         ST_GE, ST_GF: begin
            add_a          = si_ff;
            add_b          = sj_ff;
            perm_req.raddr = add_sum;
            if (state_ff == ST_GE) begin
               state_in = ST_GF;
            end else if (rsp_load) begin
               if (last_ff) begin
                  sched_done_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_byte_in  = rsp_load ? (data_ff ^ rd_data) : rsp_byte_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         sched_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         key_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         sched_done_ff <= sched_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         key_ff        <= key_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      kidx_ff     <= kidx_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // permutation memory
   rc4v_perm_ram u_perm_ram (
      .clock    (clock),
      .perm_req (perm_req),
      .rd_data  (rd_data)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // a new message always starts with the table fill
   `RC4V_ASSERT_NEXT(a_msg_start_fill, req_valid && !req_stall && !sched_done_ff, state_ff == ST_FILL)
   // end of schedule leaves both indices cleared
   `RC4V_ASSERT_NEXT(a_sched_end, state_ff == ST_KD && n_ff == 8'hFF, sched_done_ff && i_ff == 8'd0 && j_ff == 8'd0)
   // the memory is written only by fill and swap steps
   `RC4V_ASSERT_NOW(a_write_states, perm_req.we, state_ff == ST_FILL || state_ff == ST_KC || state_ff == ST_KD || state_ff == ST_GC || state_ff == ST_GD)
   // a loaded result returns the sequencer to idle with a valid output
   `RC4V_ASSERT_NEXT(a_result_load, rsp_load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

FILE: sim/rc4v_stream_checker.sv
// checker for the rc4 variant cipher: predicts each output byte and compares it
`timescale 1ns / 1ps

module rc4v_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_of_message,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rc4v_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rc4v_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              pending_bytes,
   output int                              mismatch_count
);
   import rc4v_pkg::*;

   // predicted cipher state
   logic [63:0] key_value;
   logic [7:0]  sbox [256];
   logic [7:0]  pos_i;
   logic [7:0]  pos_j;
   logic        sbox_ready;
   logic [7:0]  expected_bytes [$];

   initial begin
      mismatch_count = 0;
      pending_bytes  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // offset fill followed by the key swap pass
   function automatic void run_key_schedule();
      int         n;
      logic [7:0] acc;
      logic [7:0] tmp;
      acc = 8'd0;
      for (n = 0; n < 256; n++)
         sbox[n] = 8'(n) + PERM_OFFSET;
      for (n = 0; n < 256; n++) begin
         acc = acc + sbox[n] + key_value[8*(n % KEY_BYTES) +: 8];
         tmp = sbox[n];
         sbox[n] = sbox[acc];
         sbox[acc] = tmp;
      end
      pos_i = 8'd0;
      pos_j = 8'd0;
      sbox_ready = 1'b1;
   endfunction

   // one generator step; returns the byte xored with the keystream
   function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic last);
      logic [7:0] tmp;
      logic [7:0] stream;
      if (!sbox_ready)
         run_key_schedule();
      pos_i = pos_i + 8'd1;
      pos_j = pos_j + sbox[pos_i];
      tmp = sbox[pos_i];
      sbox[pos_i] = sbox[pos_j];
      sbox[pos_j] = tmp;
      stream = sbox[8'(sbox[pos_i] + sbox[pos_j])];
      if (last)
         sbox_ready = 1'b0;
      return data ^ stream;
   endfunction

   // watch the three ports at every edge
   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         key_value = 64'd0;
         pos_i = 8'd0;
         pos_j = 8'd0;
         sbox_ready = 1'b0;
         expected_bytes.delete();
      end else begin
         // key register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_KEY_ADDR)
            key_value = csr_pwdata;
         // output item against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("output byte %02h with nothing expected", rsp_out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want)
                  report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_out_byte, want));
            end
         end
         // input item
         if (req_valid && !req_stall)
            expected_bytes.push_back(cipher_byte(req_data_byte, req_last_of_message));
      end
      pending_bytes <= expected_bytes.size();
   end

endmodule

FILE: sim/tb_rc4_variant_stream_cipher.sv
// testbench top for the rc4 variant cipher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_rc4_variant_stream_cipher;
   import rc4v_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [CSR_ADDR_W-1:0] SPARE_CSR_ADDR = CSR_ADDR_W'(8);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  req_last_of_message;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    pending_bytes;
   int                    mismatch_count;

   // sender pacing
   int                    burst_left;
   bit                    steady;

   rc4_variant_stream_cipher i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_of_message (req_last_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   rc4v_stream_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_of_message (req_last_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .pending_bytes       (pending_bytes),
      .mismatch_count      (mismatch_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   // receiver stall pattern: calm, choppy and heavy stretches
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(30, 300);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // one input item, then maybe a gap that closes the burst
   task automatic send_byte(input logic [7:0] data, input logic last);
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_of_message <= last;
      do @(posedge clock); while (req_stall);
      if (!steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // drop valid and wait for every output item to come back
   task automatic settle();
      if (req_valid)
         req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes != 0);
   endtask

   // setup and access phases of one register write
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic change_key(input logic [63:0] value);
      settle();
      write_csr(CSR_KEY_ADDR, value);
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // stimulus
   initial begin
      int sent;
      int msg_len;
      int pick;
      int b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_last_of_message = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_left = 0;
      steady = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero key, single-byte messages at both data extremes, then a three-byte message
      change_key(64'd0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h01, 1'b1);
      // all-ones key
      change_key('1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b1);
      // key rewritten mid-message only takes effect at the next message
      change_key(64'h0123_4567_89AB_CDEF);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      change_key(64'hFEDC_BA98_7654_3210);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h12, 1'b1);
      // write to an unused address leaves the key alone
      settle();
      write_csr(SPARE_CSR_ADDR, 64'hA5A5_5A5A_0F0F_F0F0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      // single key byte set
      change_key(64'h80);
      send_byte(8'h00, 1'b1);

      // random messages, with the odd long one to wrap the index
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            msg_len = $urandom_range(200, 320);
         else if (pick < 5)
            msg_len = 1;
         else
            msg_len = $urandom_range(2, 40);
         if (msg_len > RANDOM_ITEMS - sent)
            msg_len = RANDOM_ITEMS - sent;
         if ($urandom_range(0, 2) == 0)
            change_key(pick_key());
         steady = ($urandom_range(0, 3) == 0);
         for (b = 0; b < msg_len; b++) begin
            if (b > 0 && $urandom_range(0, 49) == 0)
               change_key(pick_key());
            send_byte(8'($urandom_range(0, 255)), b == msg_len - 1);
            sent++;
         end
      end

      // drain and verdict
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
